@@ rtl/sac_pkg.sv @@
package sac_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;
  localparam logic [1:0] REG_WAYS   = 2'd3;

  // reset values of the registers
  localparam logic       RST_POLICY = 1'b0;
  localparam logic [3:0] RST_OFFSET = 4'd6;
  localparam logic [3:0] RST_INDEX  = 4'd2;
  localparam logic [3:0] RST_WAYS   = 4'd4;

  // default geometry
  localparam int DEF_MAX_SETS = 256;
  localparam int DEF_MAX_WAYS = 8;

  // address bits in use
  localparam int          ADDR_BITS = 32;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic read_row;
    logic commit;
  } sac_cmd_t;

  typedef struct packed {
    logic       policy_fifo;
    logic [3:0] offset_width;
    logic [3:0] index_width;
    logic [3:0] ways_in_use;
  } cfg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/sac_ctrl.sv @@
module sac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sac_pkg::sac_cmd_t cmd
);
  import sac_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  // nothing is taken while reset is held
  assign in_stall = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_item = (state == ST_IDLE) && in_valid;
    cmd.read_row  = (state == ST_READ);
    cmd.commit    = (state == ST_UPDATE) && out_free;
  end

endmodule

@@ rtl/sac_dp.sv @@
module sac_dp #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS
) (
  input  logic              clk,
  input  logic              rst,
  input  sac_pkg::sac_cmd_t cmd,
  input  sac_pkg::cfg_t     cfg,
  input  logic [1:0]        operation,
  input  logic [31:0]       mem_address,
  output logic              was_ignored,
  output logic              was_hit,
  output logic [31:0]       hit_total,
  output logic [31:0]       miss_total,
  output logic [31:0]       read_total,
  output logic [31:0]       write_total
);
  import sac_pkg::*;

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LEN_W   = $clog2(MAX_WAYS + 1);
  localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;

  typedef struct packed {
    logic [MAX_WAYS-1:0]             vld;
    logic [LEN_W-1:0]                len;
    logic [MAX_WAYS-1:0][WAY_W-1:0]  ord;
    logic [MAX_WAYS-1:0][31:0]       tags;
  } row_t;

  row_t              mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_valid;

  logic [1:0]  op;
  logic [31:0] addr;
  row_t        row_rd;
  logic        row_rd_valid;

  logic [31:0] hit_count, miss_count, read_count, write_count;

  logic [3:0]       iw;
  logic [LEN_W-1:0] ways;
  logic [SET_W-1:0] set_idx;
  logic [31:0]      tag;
  row_t             row_cur, row_next;
  logic             is_load, is_store, ignored, hit, do_write;
  logic [WAY_W-1:0] hit_way, free_way, victim, mv_way;
  logic             free_found, vic_found, mv_en;
  logic [LEN_W-1:0] mv_pos, vic_pos;
  logic [31:0]      hit_count_next, miss_count_next, read_count_next, write_count_next;

  // effective geometry
  always_comb begin
    iw = (cfg.index_width > 4'(IDX_LIM)) ? 4'(IDX_LIM) : cfg.index_width;
    if (cfg.ways_in_use == 4'd0) begin
      ways = LEN_W'(1);
    end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
      ways = LEN_W'(MAX_WAYS);
    end else begin
      ways = LEN_W'(cfg.ways_in_use);
    end
    set_idx = SET_W'((addr >> cfg.offset_width) & ~(32'hFFFF_FFFF << iw));
    tag     = addr >> (5'(cfg.offset_width) + 5'(iw));
  end

  // item and row registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op   <= operation;
      addr <= mem_address & ADDR_MASK;
    end
    if (cmd.read_row) begin
      row_rd       <= mem[set_idx];
      row_rd_valid <= row_valid[set_idx];
    end
    if (do_write) begin
      mem[set_idx] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (do_write) begin
      row_valid[set_idx] <= 1'b1;
    end
  end

  // lookup and replacement
  always_comb begin
    row_cur = row_rd;
    if (!row_rd_valid) begin
      row_cur.vld = '0;
      row_cur.len = '0;
    end
    is_load  = (op == OP_LOAD);
    is_store = (op == OP_STORE);
    ignored  = !is_load && !is_store;

    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (LEN_W'(w) < ways && row_cur.vld[w] && row_cur.tags[w] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end

    free_found = 1'b0;
    free_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (LEN_W'(w) < ways && !row_cur.vld[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end

    vic_found = 1'b0;
    vic_pos   = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if (LEN_W'(p) < row_cur.len && LEN_W'(row_cur.ord[p]) < ways) begin
        vic_found = 1'b1;
        vic_pos   = LEN_W'(p);
      end
    end
    victim = row_cur.ord[vic_pos[WAY_W-1:0]];

    // position of the hit way in the order list
    mv_pos = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if (LEN_W'(p) < row_cur.len && row_cur.ord[p] == hit_way) begin
        mv_pos = LEN_W'(p);
      end
    end

    row_next = row_cur;
    mv_en    = 1'b0;
    mv_way   = hit_way;
    if (hit) begin
      mv_en = !cfg.policy_fifo;
    end else if (free_found) begin
      row_next.vld[free_way]  = 1'b1;
      row_next.tags[free_way] = tag;
      if (32'(row_cur.len) < MAX_WAYS) begin
        row_next.ord[row_cur.len[WAY_W-1:0]] = free_way;
        row_next.len = row_cur.len + LEN_W'(1);
      end
    end else if (vic_found) begin
      row_next.tags[victim] = tag;
      mv_en  = 1'b1;
      mv_way = victim;
      mv_pos = vic_pos;
    end

    // remove the entry and append it at the newest end
    if (mv_en) begin
      for (int i = 0; i < MAX_WAYS - 1; i++) begin
        if (LEN_W'(i) >= mv_pos && LEN_W'(i + 1) < row_cur.len) begin
          row_next.ord[i] = row_cur.ord[i + 1];
        end
      end
      if (row_cur.len != '0) begin
        row_next.ord[WAY_W'(row_cur.len - LEN_W'(1))] = mv_way;
      end
    end

    do_write = cmd.commit && !ignored;

    read_count_next  = is_load ? sat_inc(read_count) : read_count;
    write_count_next = is_store ? sat_inc(write_count) : write_count;
    hit_count_next   = (!ignored && hit) ? sat_inc(hit_count) : hit_count;
    miss_count_next  = (!ignored && !hit) ? sat_inc(miss_count) : miss_count;
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      read_count  <= '0;
      write_count <= '0;
    end else if (cmd.commit) begin
      hit_count   <= hit_count_next;
      miss_count  <= miss_count_next;
      read_count  <= read_count_next;
      write_count <= write_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_ignored <= ignored;
      was_hit     <= !ignored && hit;
      hit_total   <= hit_count_next;
      miss_total  <= miss_count_next;
      read_total  <= read_count_next;
      write_total <= write_count_next;
    end
  end

endmodule

@@ rtl/set_assoc_cache_tag_lru_fifo_core.sv @@
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_stall   | operation, mem_address
// out      | output    | out_valid/out_stall | was_ignored, was_hit, *_total
// config   | input     | apb psel/penable    | paddr, pwdata, prdata
//
// each beat runs through accept, set row read, then update and write back
// the single-port set row memory (tags, valid bits, order list) sets the rate
// reset is synchronous; valid bits clear through one flop per set, no sweep
// a finished result sits in the output register while the next beat is taken
// out_stall holds the update cycle until the output register is free
module set_assoc_cache_tag_lru_fifo_core #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] mem_address,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_ignored,
  output logic        was_hit,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] read_total,
  output logic [31:0] write_total,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sac_pkg::*;

  cfg_t     cfg;
  sac_cmd_t cmd;
  logic     wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // registers sit on word addresses
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_fifo  <= RST_POLICY;
      cfg.offset_width <= RST_OFFSET;
      cfg.index_width  <= RST_INDEX;
      cfg.ways_in_use  <= RST_WAYS;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POLICY: cfg.policy_fifo  <= pwdata[0];
        REG_OFFSET: cfg.offset_width <= pwdata[3:0];
        REG_INDEX:  cfg.index_width  <= pwdata[3:0];
        REG_WAYS:   cfg.ways_in_use  <= pwdata[3:0];
        default:    cfg.policy_fifo  <= cfg.policy_fifo;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_POLICY: prdata = {31'd0, cfg.policy_fifo};
      REG_OFFSET: prdata = {28'd0, cfg.offset_width};
      REG_INDEX:  prdata = {28'd0, cfg.index_width};
      REG_WAYS:   prdata = {28'd0, cfg.ways_in_use};
      default:    prdata = '0;
    endcase
  end

  // sequencing of one beat
  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // set memory, tag compare, replacement and counters
  sac_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .operation   (operation),
    .mem_address (mem_address),
    .was_ignored (was_ignored),
    .was_hit     (was_hit),
    .hit_total   (hit_total),
    .miss_total  (miss_total),
    .read_total  (read_total),
    .write_total (write_total)
  );

endmodule

@@ tb/tb_set_assoc_cache_tag_lru_fifo_core.sv @@
module tb_set_assoc_cache_tag_lru_fifo_core;
  import sac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = DEF_MAX_SETS;
  localparam int NWAYS = DEF_MAX_WAYS;
  localparam int IDX_LIMIT = $clog2(DEF_MAX_SETS);
  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;
  localparam int EXP_DEPTH = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_LOAD;
  logic [31:0] mem_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        was_ignored, was_hit;
  logic [31:0] hit_total, miss_total, read_total, write_total;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_tag_lru_fifo_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected result of one access
  typedef struct packed {
    logic        ign;
    logic        hit;
    logic [31:0] hits, misses, reads, writes;
  } access_res_t;

  // expected results in order of acceptance
  access_res_t exp_ring [EXP_DEPTH];
  int          exp_head = 0, exp_tail = 0;

  // shadow cache state
  logic [31:0] tags   [NSETS][NWAYS];
  logic        valids [NSETS][NWAYS];
  int          order  [NSETS][NWAYS];
  int          order_n[NSETS];
  logic [31:0] hits_c, misses_c, reads_c, writes_c;
  cfg_t        cfg;

  int errors = 0;
  int n_sent = 0, n_got = 0, n_hits = 0;
  int stall_mode = 1;  // 0 none, 1 random

  function automatic void exp_put(input access_res_t r);
    exp_ring[exp_tail % EXP_DEPTH] = r;
    exp_tail++;
  endfunction

  function automatic access_res_t exp_take();
    access_res_t r;
    r = exp_ring[exp_head % EXP_DEPTH];
    exp_head++;
    return r;
  endfunction

  function automatic int exp_count();
    return exp_tail - exp_head;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", n_got, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // remove order entry at pos, append way at newest end
  function automatic void order_refresh(input int s, input int pos, input int way);
    for (int i = pos; i + 1 < order_n[s]; i++) order[s][i] = order[s][i + 1];
    if (order_n[s] > 0) order[s][order_n[s] - 1] = way;
  endfunction

  function automatic access_res_t cache_access(input logic [1:0] op,
                                               input logic [31:0] a);
    access_res_t r;
    int iw, ways, s, w, pos, found;
    logic [31:0] tg;
    r = '0;
    if (op == OP_LOAD) reads_c = bump(reads_c);
    else if (op == OP_STORE) writes_c = bump(writes_c);
    else begin
      r.ign = 1'b1;
      r.hits = hits_c; r.misses = misses_c; r.reads = reads_c; r.writes = writes_c;
      return r;
    end
    iw = (cfg.index_width > IDX_LIMIT) ? IDX_LIMIT : cfg.index_width;
    ways = cfg.ways_in_use;
    if (ways == 0) ways = 1;
    if (ways > NWAYS) ways = NWAYS;
    s = int'((a >> cfg.offset_width) & ((32'd1 << iw) - 1));
    tg = 32'((64'(a)) >> (cfg.offset_width + iw));
    found = -1;
    for (w = 0; w < ways; w++)
      if (valids[s][w] && tags[s][w] == tg) begin
        found = w;
        break;
      end
    if (found >= 0) begin
      hits_c = bump(hits_c);
      r.hit = 1'b1;
      if (!cfg.policy_fifo)
        for (pos = 0; pos < order_n[s]; pos++)
          if (order[s][pos] == found) begin
            order_refresh(s, pos, found);
            break;
          end
    end else begin
      misses_c = bump(misses_c);
      for (w = 0; w < ways; w++) if (!valids[s][w]) break;
      if (w < ways) begin
        valids[s][w] = 1'b1;
        tags[s][w] = tg;
        if (order_n[s] < NWAYS) begin
          order[s][order_n[s]] = w;
          order_n[s]++;
        end
      end else begin
        for (pos = 0; pos < order_n[s]; pos++) if (order[s][pos] < ways) break;
        if (pos < order_n[s]) begin
          tags[s][order[s][pos]] = tg;
          order_refresh(s, pos, order[s][pos]);
        end
      end
    end
    r.hits = hits_c; r.misses = misses_c; r.reads = reads_c; r.writes = writes_c;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // one beat on the input channel, valid stays up when the next beat follows at once
  task automatic send_access(input logic [1:0] op, input logic [31:0] a,
                             input bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    mem_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_put(cache_access(op, a));
    n_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_POLICY: cfg.policy_fifo = v[0];
      REG_OFFSET: cfg.offset_width = v[3:0];
      REG_INDEX:  cfg.index_width = v[3:0];
      default:    cfg.ways_in_use = v[3:0];
    endcase
    @(posedge clk);
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    int t;
    t = 0;
    in_valid <= 1'b0;
    while (exp_count() != 0 && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input logic pol, input logic [3:0] ofs,
                              input logic [3:0] idx, input logic [3:0] ways);
    drain();
    write_reg(REG_POLICY, {31'd0, pol});
    write_reg(REG_OFFSET, {28'd0, ofs});
    write_reg(REG_INDEX, {28'd0, idx});
    write_reg(REG_WAYS, {28'd0, ways});
  endtask

  // address from a small pool of tags so that sets fill and evict
  function automatic logic [31:0] pool_addr(input int ntags);
    logic [31:0] a;
    int iw;
    iw = (cfg.index_width > IDX_LIMIT) ? IDX_LIMIT : cfg.index_width;
    a = $urandom();
    if (cfg.offset_width + iw < 32) begin
      a = a & ((32'd1 << (cfg.offset_width + iw)) - 1);
      a = a | (32'($urandom_range(0, ntags - 1)) << (cfg.offset_width + iw));
      if ($urandom_range(0, 9) == 0) a[31] = 1'b1;
    end
    return a;
  endfunction

  function automatic logic [1:0] rand_op();
    int p;
    p = $urandom_range(0, 19);
    if (p < 9) return OP_LOAD;
    if (p < 18) return OP_STORE;
    return p[0] ? OP_OTHER : OP_RSVD;
  endfunction

  // directed: reset geometry, extremes of both fields, every op code
  task automatic test_directed();
    send_access(OP_LOAD, 32'h0000_0000, 0);
    send_access(OP_LOAD, 32'h0000_0000, 0);
    send_access(OP_STORE, 32'hFFFF_FFFF, 0);
    send_access(OP_STORE, 32'hFFFF_FFFF, 0);
    send_access(OP_OTHER, 32'hFFFF_FFFF, 0);
    send_access(OP_RSVD, 32'h0000_0000, 0);
    // fill one set past capacity, then rehit the oldest
    for (int i = 0; i < 6; i++) send_access(OP_LOAD, 32'h0000_0100 * (i + 1), 0);
    send_access(OP_LOAD, 32'h0000_0300, 0);
    send_access(OP_STORE, 32'h0000_0100, 0);
    send_access(OP_LOAD, 32'hAAAA_5555, 0);
    send_access(OP_STORE, 32'h5555_AAAA, 0);
  endtask

  task automatic test_lru_fill();
    set_geometry(1'b0, 4'd4, 4'd1, 4'd2);
    for (int i = 0; i < 120; i++) send_access(rand_op(), pool_addr(4));
  endtask

  task automatic test_fifo_fill();
    set_geometry(1'b1, 4'd4, 4'd1, 4'd2);
    for (int i = 0; i < 120; i++) send_access(rand_op(), pool_addr(4));
  endtask

  // widest geometry and out-of-range register values
  task automatic test_extremes();
    set_geometry(1'b0, 4'd12, 4'd15, 4'd8);
    for (int i = 0; i < 60; i++) send_access(rand_op(), pool_addr(12));
    set_geometry(1'b1, 4'd0, 4'd0, 4'd0);
    for (int i = 0; i < 60; i++) send_access(rand_op(), pool_addr(3));
    set_geometry(1'b0, 4'd15, 4'd8, 4'd15);
    for (int i = 0; i < 60; i++) send_access(rand_op(), pool_addr(16));
    // shrink ways while old entries stay resident
    set_geometry(1'b0, 4'd15, 4'd8, 4'd3);
    for (int i = 0; i < 60; i++) send_access(rand_op(), pool_addr(8));
  endtask

  task automatic test_random_geometry();
    for (int ph = 0; ph < 6; ph++) begin
      set_geometry(1'($urandom_range(0, 1)), 4'($urandom_range(0, 12)),
                   4'($urandom_range(0, 9)), 4'($urandom_range(1, 8)));
      stall_mode = (ph == 2) ? 0 : 1;
      for (int i = 0; i < 55; i++)
        send_access(($urandom_range(0, 9) == 0) ? 2'($urandom()) : rand_op(),
                    ($urandom_range(0, 7) == 0) ? $urandom() : pool_addr(10),
                    ph != 3);
    end
    stall_mode = 1;
  endtask

  // random output stall while stall_mode is set
  always @(posedge clk) begin
    int g;
    g = gap_len();
    out_stall <= (stall_mode != 0) && (g != 0) && ($urandom_range(0, 2) == 0);
  end

  // result checker
  always @(posedge clk) begin
    access_res_t want;
    if (!rst && out_valid && !out_stall) begin
      n_got++;
      if (exp_count() == 0) begin
        report_mismatch("unexpected beat", 32'(n_got), 32'd0);
      end else begin
        want = exp_take();
        if (was_hit) n_hits++;
        if (was_ignored !== want.ign)
          report_mismatch("was_ignored", 32'(was_ignored), 32'(want.ign));
        if (was_hit !== want.hit)
          report_mismatch("was_hit", 32'(was_hit), 32'(want.hit));
        if (hit_total !== want.hits) report_mismatch("hit_total", hit_total, want.hits);
        if (miss_total !== want.misses)
          report_mismatch("miss_total", miss_total, want.misses);
        if (read_total !== want.reads) report_mismatch("read_total", read_total, want.reads);
        if (write_total !== want.writes)
          report_mismatch("write_total", write_total, want.writes);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      order_n[s] = 0;
      for (int w = 0; w < NWAYS; w++) begin
        valids[s][w] = 1'b0;
        tags[s][w] = '0;
        order[s][w] = 0;
      end
    end
    hits_c = '0; misses_c = '0; reads_c = '0; writes_c = '0;
    cfg = '{policy_fifo: RST_POLICY, offset_width: RST_OFFSET,
            index_width: RST_INDEX, ways_in_use: RST_WAYS};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lru_fill();
    test_fifo_fill();
    test_extremes();
    test_random_geometry();
    drain();
    if (exp_count() != 0) begin
      report_mismatch("results never arrived", 32'(exp_count()), 32'd0);
    end
    $display("sent %0d accesses, checked %0d results, %0d hits", n_sent, n_got, n_hits);
    $display("covered lru and fifo, widest and narrowest geometry, ignored ops");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sac_pkg.sv
rtl/sac_ctrl.sv
rtl/sac_dp.sv
rtl/set_assoc_cache_tag_lru_fifo_core.sv
tb/tb_set_assoc_cache_tag_lru_fifo_core.sv
